@@ rtl/core/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// Page table walker package
// Shared widths, codes, result type and address helpers for the walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int VaddrWidth = 48;
   localparam int AddrWidth  = 32;
   localparam int IdxWidth   = 9;
   localparam int ReqDataWidth = 88;

   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_ENTRY     = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] LEVEL_TOP    = 2'd0;
   localparam logic [1:0] LEVEL_DIR    = 2'd2;
   localparam logic [1:0] LEVEL_BOTTOM = 2'd3;

   typedef struct packed {
      logic                 kind;
      logic [AddrWidth-1:0] address;
   } rsp_item_type;

   function automatic logic [IdxWidth-1:0] level_index(
      input logic [VaddrWidth-1:0] va,
      input logic [1:0]            lvl
   );
      logic [IdxWidth-1:0] idx;
      case (lvl)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         2'd3:    idx = va[20:12];
         default: idx = va[47:39];
      endcase
      return idx;
   endfunction

   function automatic logic [AddrWidth-1:0] entry_addr(
      input logic [AddrWidth-1:0]  base,
      input logic [VaddrWidth-1:0] va,
      input logic [1:0]            lvl
   );
      return {base[31:12], level_index(va, lvl), 3'b000};
   endfunction

endpackage

@@ rtl/core/ptw_walk_ctl.sv @@
// ----------------------------------------------------------------------------
// Page table walker control
// Holds the walk state and root register and forms the read or final address
// for each accepted beat in a single pass.
// ----------------------------------------------------------------------------
module ptw_walk_ctl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ptw_pkg::AddrWidth-1:0]  csr_value,
   input  logic                           beat_accept,
   input  logic                           beat_cmd,
   input  logic [ptw_pkg::VaddrWidth-1:0] beat_vaddr,
   input  logic                           beat_large,
   input  logic [ptw_pkg::AddrWidth-1:0]  beat_entry,
   output logic                           rsp_push,
   output ptw_pkg::rsp_item_type          rsp_item
);

   logic [ptw_pkg::AddrWidth-1:0]  table_root_ff;
   logic                           busy_ff, busy_in;
   logic [1:0]                     level_ff, level_in;
   logic [ptw_pkg::VaddrWidth-1:0] vaddr_ff, vaddr_in;
   logic                           large_ff, large_in;
   logic [1:0]                     next_level;

   assign next_level = level_ff + 2'd1;

   always_comb begin
      busy_in          = busy_ff;
      level_in         = level_ff;
      vaddr_in         = vaddr_ff;
      large_in         = large_ff;
      rsp_push         = 1'b0;
      rsp_item.kind    = ptw_pkg::KIND_READ;
      rsp_item.address = ptw_pkg::entry_addr(beat_entry, vaddr_ff, next_level);
      if (beat_accept) begin
         if (beat_cmd == ptw_pkg::CMD_TRANSLATE) begin
            if (!busy_ff) begin
               busy_in          = 1'b1;
               level_in         = ptw_pkg::LEVEL_TOP;
               vaddr_in         = beat_vaddr;
               large_in         = beat_large;
               rsp_push         = 1'b1;
               rsp_item.address = ptw_pkg::entry_addr(table_root_ff, beat_vaddr,
                                                      ptw_pkg::LEVEL_TOP);
            end
         end else if (busy_ff) begin
            rsp_push = 1'b1;
            if (level_ff == ptw_pkg::LEVEL_DIR && large_ff) begin
               busy_in          = 1'b0;
               level_in         = ptw_pkg::LEVEL_TOP;
               rsp_item.kind    = ptw_pkg::KIND_DONE;
               rsp_item.address = {beat_entry[31:21], vaddr_ff[20:0]};
            end else if (level_ff == ptw_pkg::LEVEL_BOTTOM) begin
               busy_in          = 1'b0;
               level_in         = ptw_pkg::LEVEL_TOP;
               rsp_item.kind    = ptw_pkg::KIND_DONE;
               rsp_item.address = {beat_entry[31:12], vaddr_ff[11:0]};
            end else begin
               level_in = next_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
         busy_ff       <= 1'b0;
         level_ff      <= ptw_pkg::LEVEL_TOP;
         vaddr_ff      <= '0;
         large_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            table_root_ff <= csr_value;
         end
         busy_ff  <= busy_in;
         level_ff <= level_in;
         vaddr_ff <= vaddr_in;
         large_ff <= large_in;
      end
   end

endmodule

@@ rtl/core/ptw_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// Page table walker result buffer
// Two-entry output queue that decouples the result beat from the input side.
// ----------------------------------------------------------------------------
module ptw_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptw_pkg::rsp_item_type push_item,
   output logic                  not_full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ptw_pkg::rsp_item_type out_item
);

   ptw_pkg::rsp_item_type entries_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   assign out_valid = (count_ff != 2'd0);
   assign not_full  = (count_ff != 2'd2);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/page_table_walker_unit.sv @@
// ----------------------------------------------------------------------------
// Page table walker unit
// Four-level page table walker: issues entry reads and reports the physical
// address of a translated virtual address.
// ----------------------------------------------------------------------------
// A translate beat (tuser 0) starts a walk and yields a read request for the
// top-level entry; each returned entry beat (tuser 1) yields the next read or,
// after three levels for a large page or four otherwise, the physical
// address. The unit accepts one beat per clock cycle and registers each
// result in a two-entry result buffer, so it keeps accepting while a result
// waits; the input stalls only when that buffer is full. A translate beat
// during a walk and an entry beat while idle are consumed without a result.
// The root register resets to zero and is written through the csr channel;
// the user must do so only while the unit is idle; the unit does not check.
module page_table_walker_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptw_pkg::AddrWidth-1:0]     csr_data,     // table_root
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // virt_addr, large_page, entry_data, zero fill
   input  logic [ptw_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              req_tuser,    // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptw_pkg::AddrWidth-1:0]     rsp_tdata,    // address
   output logic                              rsp_tuser     // kind
);

   logic                  beat_accept;
   logic                  fifo_not_full;
   logic                  rsp_push;
   ptw_pkg::rsp_item_type rsp_item;
   ptw_pkg::rsp_item_type out_item;

   assign csr_ready   = 1'b1;
   assign req_tready  = fifo_not_full;
   assign beat_accept = req_tvalid && fifo_not_full;

   ptw_walk_ctl u_walk (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_valid),
      .csr_value   (csr_data),
      .beat_accept (beat_accept),
      .beat_cmd    (req_tuser),
      .beat_vaddr  (req_tdata[47:0]),
      .beat_large  (req_tdata[48]),
      .beat_entry  (req_tdata[80:49]),
      .rsp_push    (rsp_push),
      .rsp_item    (rsp_item)
   );

   ptw_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .not_full  (fifo_not_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.address;
   assign rsp_tuser = out_item.kind;

endmodule
